// ===== rtl/core/des_key_schedule_unit_defines.svh =====
// ----------------------------------------------------------------------------
// DES key schedule assertion macros
// Shared property wrappers. Each one is clocked on clk and held off during
// reset through arst_n.
// ----------------------------------------------------------------------------
`ifndef DES_KEY_SCHEDULE_UNIT_DEFINES_SVH
`define DES_KEY_SCHEDULE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/deskey_pkg.sv =====
// ----------------------------------------------------------------------------
// deskey_pkg
// Constants, permutation tables and helper functions for the DES key schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deskey_pkg;

	localparam int KEY_W   = 64;
	localparam int CD_W    = 56;
	localparam int HALF_W  = 28;
	localparam int SUB_W   = 48;
	localparam int ROUNDS  = 16;
	localparam int RND_W   = $clog2(ROUNDS);
	localparam int IDX_W   = 5;

	localparam logic [RND_W-1:0] ROUND_LAST = RND_W'(ROUNDS - 1);

	// Bit r is set when round r+1 rotates the halves by two places.
	localparam logic [ROUNDS-1:0] ROT_TWO = 16'h7EFC;

	localparam byte unsigned PC1_TAB [CD_W] = '{
		8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
		8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
		8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
		8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
		8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
		8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
		8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
		8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
	};

	localparam byte unsigned PC2_TAB [SUB_W] = '{
		8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
		8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
		8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
		8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
		8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
		8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
		8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
		8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
	};

	// One round on its way from the generator into the pipeline.
	typedef struct packed {
		logic [CD_W-1:0]  cd;
		logic [RND_W-1:0] rnd;
	} deskey_round_t;

	// Table positions count from 1 at the most significant bit.
	function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
		logic [CD_W-1:0] res;
		res = '0;
		for (int i = 0; i < CD_W; i++) begin
			res[CD_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
		end
		return res;
	endfunction

	function automatic logic [SUB_W-1:0] pc2(input logic [CD_W-1:0] cd);
		logic [SUB_W-1:0] res;
		res = '0;
		for (int i = 0; i < SUB_W; i++) begin
			res[SUB_W-1-i] = cd[CD_W - int'(PC2_TAB[i])];
		end
		return res;
	endfunction

	function automatic logic [HALF_W-1:0] rotl_half(input logic [HALF_W-1:0] h,
			input logic two);
		logic [HALF_W-1:0] res;
		if (two) begin
			res = {h[HALF_W-3:0], h[HALF_W-1:HALF_W-2]};
		end else begin
			res = {h[HALF_W-2:0], h[HALF_W-1]};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/deskey_round_gen.sv =====
// ----------------------------------------------------------------------------
// deskey_round_gen
// Takes a key, applies PC1 and steps the C and D halves through the sixteen
// rotations, offering one rotated C:D per cycle, while adv is high, to the subkey pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deskey_round_gen
	import deskey_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 key_valid,
	output logic                      key_ready,
	input  wire logic [KEY_W-1:0]     key_in,
	input  wire logic                 adv,
	output logic                      rnd_valid,
	output deskey_round_t             rnd_out
);

	logic [HALF_W-1:0] c_q, d_q;
	logic [RND_W-1:0]  rnd_q;
	logic              busy_q;
	logic [HALF_W-1:0] c_rot, d_rot;
	logic [CD_W-1:0]   cd_init;
	logic              key_acc;
	logic              step;
	logic              at_last;

	assign cd_init = pc1(key_in);
	assign c_rot   = rotl_half(c_q, ROT_TWO[rnd_q]);
	assign d_rot   = rotl_half(d_q, ROT_TWO[rnd_q]);
	assign at_last = (rnd_q == ROUND_LAST);
	assign step    = busy_q && adv;

	// A new key may load in the same cycle the last round of the old one leaves.
	assign key_ready = !busy_q || (at_last && adv);
	assign key_acc   = key_valid && key_ready;

	assign rnd_valid  = busy_q;
	assign rnd_out.cd  = {c_rot, d_rot};
	assign rnd_out.rnd = rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
		end else if (key_acc) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (step) begin
			busy_q <= !at_last;
			rnd_q  <= rnd_q + RND_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (key_acc) begin
			c_q <= cd_init[CD_W-1:HALF_W];
			d_q <= cd_init[HALF_W-1:0];
		end else if (step) begin
			c_q <= c_rot;
			d_q <= d_rot;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/des_key_schedule_unit.sv =====
// ----------------------------------------------------------------------------
// des_key_schedule_unit
// Expands one 64-bit DES key into its sixteen 48-bit round subkeys.
// ----------------------------------------------------------------------------
// Usage:
// A key is taken on the key channel (key_valid/key_ready). The sixteen
// subkeys leave on the output channel (out_valid/out_ready) in round order,
// one beat each, tagged with round_index 1..16 and with last_round on 16.
// The first subkey passes the generator's C and D registers, then the rotated C:D, PC2 and output stages.
// Throughput: one subkey beat per cycle while out_ready is high;
// the next key is taken in the cycle its predecessor's round 16 enters the
// pipeline, so subkeys of successive keys follow without a gap.
// The rate is set by the round generator, which holds the C and D halves in
// one register pair and rotates them once per cycle when not stalled.
// Behind it sit three register stages: rotated C:D, PC2 result, and the
// output register. Each stage moves only when the one after it is free or
// emptying, so a stall on out_ready holds every beat in place and fills the
// empty stages; key_ready drops once the generator backs up.
// Reset clears all valid bits and the generator; no beat is in flight after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module des_key_schedule_unit
	import deskey_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              key_valid,
	output logic                   key_ready,
	input  wire logic [KEY_W-1:0]  key_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [SUB_W-1:0]       round_key,
	output logic [IDX_W-1:0]       round_index,
	output logic                   last_round
);

	logic          gen_valid;
	deskey_round_t gen_rnd;

	logic              v_s1, v_s2, v_s3;
	deskey_round_t     rnd_s1;
	logic [SUB_W-1:0]  key_s2, key_s3;
	logic [RND_W-1:0]  rnd_s2;
	logic [IDX_W-1:0]  idx_s3;
	logic              last_s3;
	logic              en1, en2, en3;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	deskey_round_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_ready (key_ready),
		.key_in    (key_in),
		.adv       (en1),
		.rnd_valid (gen_valid),
		.rnd_out   (gen_rnd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= gen_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			rnd_s1 <= gen_rnd;
		end
		if (en2) begin
			key_s2 <= pc2(rnd_s1.cd);
			rnd_s2 <= rnd_s1.rnd;
		end
		if (en3) begin
			key_s3  <= key_s2;
			idx_s3  <= IDX_W'(rnd_s2) + IDX_W'(1);
			last_s3 <= (rnd_s2 == ROUND_LAST);
		end
	end

	assign out_valid   = v_s3;
	assign round_key   = key_s3;
	assign round_index = idx_s3;
	assign last_round  = last_s3;

endmodule

`default_nettype wire

// ===== rtl/core/deskey_checker.sv =====
// ----------------------------------------------------------------------------
// deskey_checker
// Port-level checks on the DES key schedule, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "des_key_schedule_unit_defines.svh"

module deskey_checker
	import deskey_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              key_valid,
	input wire logic              key_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [SUB_W-1:0]  round_key,
	input wire logic [IDX_W-1:0]  round_index,
	input wire logic              last_round
);

	logic                   is_final;
	logic                   idx_ok;
	logic                   stalled;
	logic [SUB_W+IDX_W:0]   beat_bits;

	assign is_final  = (round_index == IDX_W'(ROUNDS));
	assign idx_ok    = (round_index >= IDX_W'(1)) && (round_index <= IDX_W'(ROUNDS));
	assign stalled   = out_valid && !out_ready;
	assign beat_bits = {round_key, round_index, last_round};

	// The last flag and round sixteen must always travel together.
	`DKS_ASSERT_NOW(a_last_idx, out_valid, last_round == is_final, "last_round disagrees with round_index")
	`DKS_ASSERT_NOW(a_idx_range, out_valid, idx_ok, "round_index out of range")
	// A freshly loaded key occupies the generator, so key_ready drops after a key beat.
	`DKS_ASSERT_NEXT(a_key_busy, key_valid && key_ready, !key_ready, "key_ready high after a key beat")
	`DKS_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(beat_bits), "stalled beat changed")

endmodule

bind des_key_schedule_unit deskey_checker u_deskey_checker (.*);

`default_nettype wire
